>>> src/adaptive_threshold_flash_trigger_core_defines.svh
// Assertion macros shared by the flash trigger checker.
`ifndef ADAPTIVE_THRESHOLD_FLASH_TRIGGER_CORE_DEFINES_SVH
`define ADAPTIVE_THRESHOLD_FLASH_TRIGGER_CORE_DEFINES_SVH

// Same-cycle implication.
`define ATFT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ATFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/atft_pkg.sv
// Types, constants and helpers of the adaptive threshold flash trigger.
package atft_pkg;

   localparam int ACTION_W = 3;
   localparam int SAMPLE_W = 12;
   localparam int LEVEL_W  = 7;
   localparam int THR_W    = 14;
   localparam int SINCE_W  = 17;
   localparam int HOLD_W   = 16;
   localparam int CSR_ADDR_W = 2;

   localparam int REQ_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;
   localparam int RSP_BITS    = 1 + LEVEL_W + THR_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [ACTION_W-1:0] ACT_SAMPLE = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_UP     = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_DOWN   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_TEST   = 3'd4;

   localparam logic [CSR_ADDR_W-1:0] CSR_TRIG_EN = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MANUAL  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_HOLDOFF = 2'd2;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 7'd100;
   localparam logic [LEVEL_W-1:0] LEVEL_RESET   = 7'd20;
   localparam logic [THR_W-1:0]   THR_MIN       = 14'd1000;
   localparam logic [THR_W-1:0]   THR_MAX       = 14'd11000;
   localparam logic [THR_W-1:0]   THR_STEP      = 14'd1000;
   localparam logic [THR_W-1:0]   THR_RESET     = 14'd5000;
   localparam logic [THR_W-1:0]   TARGET_OFFSET = 14'd1000;
   localparam logic [THR_W-1:0]   SNAP_BAND     = 14'd100;
   localparam logic [THR_W-1:0]   LEVEL_SCALE   = 14'd100;
   localparam logic [SINCE_W-1:0] SINCE_MAX     = {SINCE_W{1'b1}};
   localparam logic [HOLD_W-1:0]  HOLD_RESET    = 16'd1000;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [SAMPLE_W-1:0] adc_sample;
   } item_type;

   typedef struct packed {
      logic              trigger_enabled;
      logic              manual_mode;
      logic [HOLD_W-1:0] holdoff_ms;
   } cfg_type;

   // fire lands in bit 0 when packed onto the bus
   typedef struct packed {
      logic [THR_W-1:0]   threshold_level;
      logic [LEVEL_W-1:0] light_level;
      logic               fire;
   } result_type;

   function automatic logic [THR_W-1:0] level_x100(input logic [LEVEL_W-1:0] lvl);
      return {{(THR_W-LEVEL_W){1'b0}}, lvl} * LEVEL_SCALE;
   endfunction

   function automatic logic [THR_W-1:0] clamp_thr(input logic [THR_W-1:0] v);
      logic [THR_W-1:0] r;
      r = v;
      if (v < THR_MIN) begin
         r = THR_MIN;
      end else if (v > THR_MAX) begin
         r = THR_MAX;
      end
      return r;
   endfunction

endpackage

>>> src/atft_level_map.sv
// Maps a raw light sample to a level of 100 - sample/20, floored at 0.
module atft_level_map
   import atft_pkg::*;
#(
   parameter int ADC_BITS = 12
) (
   input  logic [SAMPLE_W-1:0] adc_sample,
   output logic [LEVEL_W-1:0]  light_level
);

   localparam int QUARTER_W = SAMPLE_W - 2;
   localparam int PROD_W    = QUARTER_W + 8;

   logic [SAMPLE_W-1:0]  sample_masked;
   logic [QUARTER_W-1:0] quarter;
   logic [PROD_W-1:0]    prod;
   logic [7:0]           drop;

   always_comb begin
      for (int i = 0; i < SAMPLE_W; i++) begin
         sample_masked[i] = (i < ADC_BITS) ? adc_sample[i] : 1'b0;
      end
   end

   // sample/20 = (sample/4)/5; x*205 >> 10 is exact for x below 1024
   assign quarter = sample_masked[SAMPLE_W-1:2];
   assign prod    = {8'd0, quarter} * PROD_W'(205);
   assign drop    = prod[PROD_W-1:10];

   assign light_level = (drop >= {1'b0, LEVEL_MAX}) ? '0 : LEVEL_MAX - drop[LEVEL_W-1:0];

endmodule

>>> src/atft_track.sv
// Trigger state: level, self-adjusting threshold and time since the last fire.
module atft_track
   import atft_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  item_type           item,
   input  cfg_type            cfg,
   input  logic [LEVEL_W-1:0] sample_level,
   output result_type         result
);

   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [THR_W-1:0]   thr_ff, thr_in;
   logic [SINCE_W-1:0] since_ff, since_in;
   logic               fire;

   logic [THR_W-1:0]   target;
   logic [THR_W-1:0]   diff;
   logic [THR_W-1:0]   thr_down;
   logic [SINCE_W-1:0] since_sat;

   assign target    = level_x100(level_ff) + TARGET_OFFSET;
   assign diff      = (target > thr_ff) ? target - thr_ff : thr_ff - target;
   assign thr_down  = (thr_ff > THR_STEP) ? thr_ff - THR_STEP : '0;
   assign since_sat = (since_ff == SINCE_MAX) ? since_ff : since_ff + SINCE_W'(1);

   always_comb begin
      level_in = level_ff;
      thr_in   = thr_ff;
      since_in = since_ff;
      fire     = 1'b0;
      case (item.action)
         ACT_SAMPLE: begin
            level_in = sample_level;
            if (cfg.trigger_enabled && (level_x100(sample_level) > thr_ff) &&
                (since_ff > {1'b0, cfg.holdoff_ms})) begin
               fire     = 1'b1;
               since_in = '0;
            end
         end
         ACT_TICK: begin
            since_in = since_sat;
            if (!cfg.manual_mode) begin
               // snap inside the band, else slew one hundredth toward target
               if (diff < SNAP_BAND) begin
                  thr_in = target;
               end else if (target > thr_ff) begin
                  thr_in = clamp_thr(thr_ff + THR_W'(1));
               end else begin
                  thr_in = clamp_thr(thr_ff - THR_W'(1));
               end
            end
         end
         ACT_UP: begin
            if (cfg.manual_mode) begin
               thr_in = clamp_thr(thr_ff + THR_STEP);
            end
         end
         ACT_DOWN: begin
            if (cfg.manual_mode) begin
               thr_in = clamp_thr(thr_down);
            end
         end
         ACT_TEST: begin
            fire     = 1'b1;
            since_in = '0;
         end
         default: begin
         end
      endcase
   end

   assign result.fire            = fire;
   assign result.light_level     = level_in;
   assign result.threshold_level = thr_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= LEVEL_RESET;
         thr_ff   <= THR_RESET;
         since_ff <= '0;
      end else if (advance) begin
         level_ff <= level_in;
         thr_ff   <= thr_in;
         since_ff <= since_in;
      end
   end

endmodule

>>> src/adaptive_threshold_flash_trigger_core.sv
// Adaptive threshold flash trigger: one result beat per request beat.
//
// Request channel req_*: each beat is a light sample, a millisecond tick,
// a threshold step up or down, or a test fire, chosen by req_tuser.
// Result channel rsp_*: one beat per request with the fire flag, the
// light level and the threshold in hundredths of a level after the item.
// Config port csr_*: index 0 trigger enable, 1 manual mode, 2 hold-off in
// ms; write only while no request is in flight.
//
// Path: the beat is registered in the input register when it is accepted, and
// its result is loaded into the output register once that register is free;
// rsp_tvalid is driven by the output register. Throughput is one beat per cycle
// while rsp_tready does not stall, set by the single update stage between the two registers.
// A stalled rsp_tready holds the result; one more request is taken into
// the input register, then req_tready drops until the result is taken.
// Reset clears both stages, sets level 20, threshold 5000, the fire
// timer to 0 and the config to disabled, auto mode, 1000 ms hold-off.
module adaptive_threshold_flash_trigger_core
   import atft_pkg::*;
#(
   parameter int ADC_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // adc_sample[11:0], zero pad
   input  logic [ACTION_W-1:0]    req_tuser,  // action[2:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // fire, light_level, threshold_level, pad
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [HOLD_W-1:0]      csr_wdata
);

   item_type   item_ff, item_in;
   logic       item_valid_ff, item_valid_in;
   result_type rsp_data_ff, rsp_data_in;
   logic       rsp_valid_ff, rsp_valid_in;
   cfg_type    cfg_ff, cfg_in;

   logic               out_free;
   logic               advance;
   logic               req_take;
   logic [LEVEL_W-1:0] sample_level;
   result_type         result;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = item_valid_ff && out_free;
   assign req_tready = !item_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   atft_level_map #(
      .ADC_BITS(ADC_BITS)
   ) u_map (
      .adc_sample (item_ff.adc_sample),
      .light_level(sample_level)
   );

   atft_track u_track (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .item        (item_ff),
      .cfg         (cfg_ff),
      .sample_level(sample_level),
      .result      (result)
   );

   always_comb begin
      item_in       = req_take ? item_type'({req_tuser, req_tdata[SAMPLE_W-1:0]}) : item_ff;
      item_valid_in = req_take || (item_valid_ff && !advance);
      rsp_data_in   = advance ? result : rsp_data_ff;
      rsp_valid_in  = advance || (rsp_valid_ff && !rsp_tready);
      cfg_in        = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_TRIG_EN: cfg_in.trigger_enabled = csr_wdata[0];
            CSR_MANUAL:  cfg_in.manual_mode     = csr_wdata[0];
            CSR_HOLDOFF: cfg_in.holdoff_ms      = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         item_valid_ff          <= 1'b0;
         rsp_valid_ff           <= 1'b0;
         cfg_ff.trigger_enabled <= 1'b0;
         cfg_ff.manual_mode     <= 1'b0;
         cfg_ff.holdoff_ms      <= HOLD_RESET;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         cfg_ff        <= cfg_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-RSP_BITS){1'b0}}, rsp_data_ff};

endmodule

>>> src/atft_checker.sv
// Port-level checks on the flash trigger, bound to the top level.
`include "adaptive_threshold_flash_trigger_core_defines.svh"

module atft_checker
   import atft_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [THR_W-1:0]   rsp_thr;
   logic [LEVEL_W-1:0] rsp_level;

   assign rsp_thr   = rsp_tdata[THR_W+LEVEL_W:LEVEL_W+1];
   assign rsp_level = rsp_tdata[LEVEL_W:1];

   `ATFT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                     rsp_tvalid && $stable(rsp_tdata), "stalled result beat changed")

   `ATFT_ASSERT_IMPLY(a_thr_range, clock, reset, rsp_tvalid,
                      (rsp_thr >= THR_MIN) && (rsp_thr <= THR_MAX), "threshold out of range")

   `ATFT_ASSERT_IMPLY(a_level_range, clock, reset, rsp_tvalid,
                      rsp_level <= LEVEL_MAX, "light level above full scale")

   `ATFT_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset,
                     !rsp_tvalid && req_tready, "pipeline not empty after reset")

endmodule

bind adaptive_threshold_flash_trigger_core atft_checker u_atft_checker (.*);
